@@ design/coin_change_dp_assert.svh @@
// ----------------------------------------------------------------------------
// coin_change_dp_assert.svh
// Assertion macros for the coin change block. Expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef COIN_CHANGE_DP_ASSERT_SVH
`define COIN_CHANGE_DP_ASSERT_SVH

// Same-cycle implication
`define CCDP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CCDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ccdp_pkg.sv @@
// ----------------------------------------------------------------------------
// ccdp_pkg
// Types, constants and codes shared by the coin change block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccdp_pkg;

  localparam int MODE_W   = 2;
  localparam int COIN_W   = 10;
  localparam int AMT_W    = 10;
  localparam int MIN_W    = 10;
  localparam int WAYS_W   = 63;
  localparam int AMT_SPAN = 1 << AMT_W;

  localparam int MAX_COINS_DEF  = 8;
  localparam int MAX_AMOUNT_DEF = 1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_STORED   = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_CLEARED  = 2'd2,
    STAT_ANSWERED = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2,
    S_WRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [COIN_W-1:0] coin_value;
    logic [AMT_W-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    stat_t             status;
    logic              reachable;
    logic [MIN_W-1:0]  min_coins;
    logic [WAYS_W-1:0] ways;
    logic              ways_saturated;
  } out_item_t;

  // One row of the DP table
  typedef struct packed {
    logic              reach;
    logic [MIN_W-1:0]  min_coins;
    logic              sat;
    logic [WAYS_W-1:0] ways;
  } tbl_entry_t;

  typedef struct packed {
    logic  load_item;
    logic  coin_wr;
    logic  count_clr;
    logic  init;
    logic  coin_rd;
    logic  tbl_wr;
    logic  out_load;
    stat_t status;
  } ccdp_cmd_t;

  typedef struct packed {
    logic coin_zero;
    logic full;
    logic amt_oob;
    logic cnt_zero;
    logic last_coin;
    logic last_amt;
    logic target_zero;
    logic out_free;
  } ccdp_sts_t;

endpackage

`default_nettype wire

@@ design/ccdp_if.sv @@
// ----------------------------------------------------------------------------
// ccdp_if
// Valid/ready channels carrying input and result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ccdp_in_if;
  import ccdp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccdp_out_if;
  import ccdp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/coin_change_dp.sv @@
// Coin add, clear and rejected transactions go from idle to the response
// state, which loads the result register once that register is free. A query
// of amount A fills the DP table sequentially (one coin lookup per cycle, one
// table row per amount) before it reaches the response state.
// One transaction in flight; the next is accepted while a result waits.
// Synchronous active-low reset empties the coin set; table RAMs are not cleared.
// ----------------------------------------------------------------------------
// coin_change_dp
// Minimum-coin and ordered-ways coin change solver, bottom-up DP.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "coin_change_dp_assert.svh"

module coin_change_dp #(
  parameter int MAX_COINS  = ccdp_pkg::MAX_COINS_DEF,
  parameter int MAX_AMOUNT = ccdp_pkg::MAX_AMOUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ccdp_in_if.sink           in_ch,
  ccdp_out_if.source        out_ch
);
  import ccdp_pkg::*;

  ccdp_cmd_t cmd;
  ccdp_sts_t sts;
  logic      in_ready;

  ccdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.data.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccdp_dpath #(.MAX_COINS(MAX_COINS), .MAX_AMOUNT(MAX_AMOUNT)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .out_ready (out_ch.ready)
  );

  assign in_ch.ready = in_ready;

  `CCDP_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ready, !in_ready, "accepted while busy")
  `CCDP_ASSERT_IMPL(a_cmd_exclusive, 1'b1, $onehot0({cmd.coin_rd, cmd.tbl_wr, cmd.init, cmd.out_load}), "conflicting commands")
  `CCDP_ASSERT_IMPL(a_unreach_min_zero, out_ch.valid && (out_ch.data.status == STAT_ANSWERED) && !out_ch.data.reachable, out_ch.data.min_coins == '0, "min_coins set for unreachable amount")
  `CCDP_ASSERT_IMPL(a_non_query_zero, out_ch.valid && (out_ch.data.status != STAT_ANSWERED), !out_ch.data.reachable && (out_ch.data.ways == '0) && !out_ch.data.ways_saturated, "answer fields on non-query result")

endmodule

`default_nettype wire

@@ design/ccdp_ram.sv @@
// ----------------------------------------------------------------------------
// ccdp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccdp_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/ccdp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccdp_ctrl
// Sequencer: decodes transactions and steps the DP fill over amounts/coins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccdp_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [ccdp_pkg::MODE_W-1:0] in_mode,
  output logic                        in_ready,
  input  ccdp_pkg::ccdp_sts_t         sts,
  output ccdp_pkg::ccdp_cmd_t         cmd
);
  import ccdp_pkg::*;

  state_t state_r, state_nxt;
  stat_t  stat_r, stat_nxt;
  logic   coin_ok;

  assign coin_ok = !sts.coin_zero && !sts.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= STAT_REJECTED;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RESP;
          case (in_mode)
            MODE_ADD:   stat_nxt = coin_ok ? STAT_STORED : STAT_REJECTED;
            MODE_CLEAR: stat_nxt = STAT_CLEARED;
            MODE_QUERY: begin
              if (sts.amt_oob) begin
                stat_nxt = STAT_REJECTED;
              end else begin
                stat_nxt  = STAT_ANSWERED;
                state_nxt = S_INIT;
              end
            end
            default:    stat_nxt = STAT_REJECTED;
          endcase
        end
      end
      S_INIT: begin
        if (sts.target_zero) begin
          state_nxt = S_RESP;
        end else if (sts.cnt_zero) begin
          state_nxt = S_DRAIN1;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE:  if (sts.last_coin) state_nxt = S_DRAIN1;
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_WRITE;
      S_WRITE: begin
        if (sts.last_amt) begin
          state_nxt = S_RESP;
        end else if (sts.cnt_zero) begin
          state_nxt = S_DRAIN1;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_RESP:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.status = stat_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        cmd.coin_wr   = in_valid && (in_mode == MODE_ADD) && coin_ok;
        cmd.count_clr = in_valid && (in_mode == MODE_CLEAR);
      end
      S_INIT:   cmd.init     = 1'b1;
      S_ISSUE:  cmd.coin_rd  = 1'b1;
      S_WRITE:  cmd.tbl_wr   = 1'b1;
      S_RESP:   cmd.out_load = sts.out_free;
      default:  cmd.status   = stat_r;
    endcase
  end

endmodule

`default_nettype wire

@@ design/ccdp_dpath.sv @@
// ----------------------------------------------------------------------------
// ccdp_dpath
// Coin store, DP table, two-stage lookup pipeline, accumulators, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccdp_dpath #(
  parameter int MAX_COINS  = ccdp_pkg::MAX_COINS_DEF,
  parameter int MAX_AMOUNT = ccdp_pkg::MAX_AMOUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ccdp_pkg::ccdp_cmd_t cmd,
  output ccdp_pkg::ccdp_sts_t sts,
  input  ccdp_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ccdp_pkg::out_item_t out_data,
  input  logic                out_ready
);
  import ccdp_pkg::*;

  localparam int CIW       = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CCW       = $clog2(MAX_COINS + 1);
  localparam int TBL_DEPTH = (MAX_AMOUNT > AMT_SPAN) ? AMT_SPAN : MAX_AMOUNT;
  localparam int TAW       = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int TBL_W     = $bits(tbl_entry_t);
  localparam logic [16:0] AMT_LIMIT = 17'(MAX_AMOUNT);

  logic [CCW-1:0]    count_r, count_nxt;
  logic [CCW-1:0]    idx_r, idx_nxt;
  logic [AMT_W-1:0]  target_r, target_nxt;
  logic [AMT_W-1:0]  amt_r, amt_nxt;
  logic              s1_v_r, s2_v_r, s2_v_nxt;
  logic              any_r, any_nxt;
  logic [MIN_W-1:0]  best_r, best_nxt;
  logic              sat_r, sat_nxt;
  logic [WAYS_W-1:0] cnt_r, cnt_nxt;
  tbl_entry_t        res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [COIN_W-1:0] coin_rdata;
  logic [TBL_W-1:0]  tbl_rdata_raw;
  tbl_entry_t        tbl_rdata, init_entry, acc_entry, tbl_wdata;
  logic [AMT_W-1:0]  prev_amt;
  logic [TAW-1:0]    tbl_waddr;
  logic [MIN_W-1:0]  cand;
  logic [WAYS_W:0]   sum;

  // coin denominations
  ccdp_ram #(.WIDTH(COIN_W), .DEPTH(MAX_COINS)) u_coin_ram (
    .clk     (clk),
    .wr_en   (cmd.coin_wr),
    .wr_addr (count_r[CIW-1:0]),
    .wr_data (in_data.coin_value),
    .rd_en   (cmd.coin_rd),
    .rd_addr (idx_r[CIW-1:0]),
    .rd_data (coin_rdata)
  );

  // stage 1: coin back from RAM, look up amt - coin
  assign prev_amt = amt_r - coin_rdata;
  assign s2_v_nxt = s1_v_r && (coin_rdata != '0) && (coin_rdata <= amt_r);

  ccdp_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
    .clk     (clk),
    .wr_en   (cmd.tbl_wr || cmd.init),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_en   (s2_v_nxt),
    .rd_addr (prev_amt[TAW-1:0]),
    .rd_data (tbl_rdata_raw)
  );

  assign tbl_rdata = tbl_rdata_raw;

  always_comb begin
    init_entry           = '0;
    init_entry.reach     = 1'b1;
    init_entry.ways      = WAYS_W'(1);
    acc_entry.reach      = any_r;
    acc_entry.min_coins  = any_r ? best_r : '0;
    acc_entry.sat        = sat_r;
    acc_entry.ways       = cnt_r;
    tbl_wdata            = cmd.init ? init_entry : acc_entry;
    tbl_waddr            = cmd.init ? '0 : amt_r[TAW-1:0];
  end

  // stage 2: fold one previous entry into the accumulators
  assign cand = tbl_rdata.min_coins + 1'b1;
  assign sum  = {1'b0, cnt_r} + {1'b0, tbl_rdata.ways};

  always_comb begin
    any_nxt  = any_r;
    best_nxt = best_r;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    if (cmd.init || cmd.tbl_wr) begin
      any_nxt  = 1'b0;
      best_nxt = '0;
      sat_nxt  = 1'b0;
      cnt_nxt  = '0;
    end else if (s2_v_r) begin
      if (tbl_rdata.reach) begin
        any_nxt = 1'b1;
        if (!any_r || (cand < best_r)) begin
          best_nxt = cand;
        end
      end
      if (sum[WAYS_W]) begin
        cnt_nxt = '1;
        sat_nxt = 1'b1;
      end else begin
        cnt_nxt = sum[WAYS_W-1:0];
        sat_nxt = sat_r || tbl_rdata.sat;
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    target_nxt = target_r;
    amt_nxt    = amt_r;
    res_nxt    = res_r;
    if (cmd.coin_wr)   count_nxt = count_r + 1'b1;
    if (cmd.count_clr) count_nxt = '0;
    if (cmd.load_item) target_nxt = in_data.amount;
    if (cmd.coin_rd)   idx_nxt = idx_r + 1'b1;
    if (cmd.init) begin
      amt_nxt = AMT_W'(1);
      idx_nxt = '0;
      res_nxt = init_entry;
    end
    if (cmd.tbl_wr) begin
      amt_nxt = amt_r + 1'b1;
      idx_nxt = '0;
      res_nxt = acc_entry;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt.status = cmd.status;
      if (cmd.status == STAT_ANSWERED) begin
        out_data_nxt.reachable      = res_r.reach;
        out_data_nxt.min_coins      = res_r.min_coins;
        out_data_nxt.ways           = res_r.ways;
        out_data_nxt.ways_saturated = res_r.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      s1_v_r      <= cmd.coin_rd;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    target_r   <= target_nxt;
    amt_r      <= amt_nxt;
    any_r      <= any_nxt;
    best_r     <= best_nxt;
    sat_r      <= sat_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    sts.coin_zero   = (in_data.coin_value == '0);
    sts.full        = (count_r == CCW'(MAX_COINS));
    sts.amt_oob     = ({7'b0, in_data.amount} >= AMT_LIMIT);
    sts.cnt_zero    = (count_r == '0);
    sts.last_coin   = (CCW'(idx_r + 1'b1) == count_r);
    sts.last_amt    = (amt_r == target_r);
    sts.target_zero = (target_r == '0);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
